// File: design/pnc_pkg.sv
`default_nettype none

package pnc_pkg;

    // fixed shape of the block
    localparam int NUM_CHANNELS = 3;
    localparam int MAX_DIM      = 4096;

    localparam int PIX_W        = 8;
    localparam int CH_W         = 2;
    localparam int CNT_W        = $clog2(MAX_DIM);
    localparam int DIM_W        = CNT_W + 1;
    localparam int AREA_W       = 2 * CNT_W + 1;
    localparam int IDX_W        = 26;
    localparam int MEAN_W       = 16;
    localparam int SCALE_W      = 24;
    localparam int NORM_W       = 24;
    localparam int DIFF_W       = MEAN_W + 1;
    localparam int PROD_W       = DIFF_W + SCALE_W + 1;
    localparam int FRAC_SHIFT   = 16;
    localparam int QUOT_W       = PROD_W - FRAC_SHIFT;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_CH0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_CH1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_CH2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_CH0    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_CH1    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_CH2    = 3'd7;

    // register reset values
    localparam logic [DIM_W-1:0]   DIM_RESET   = 13'd1;
    localparam logic [MEAN_W-1:0]  MEAN_RESET  = 16'd0;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

    localparam logic signed [NORM_W-1:0] NORM_MAX = 24'sh7FFFFF;
    localparam logic signed [NORM_W-1:0] NORM_MIN = 24'sh800000;

    typedef struct packed {
        logic [DIM_W-1:0]                          height;
        logic [DIM_W-1:0]                          width;
        logic [AREA_W-1:0]                         area;
        logic [NUM_CHANNELS-1:0][MEAN_W-1:0]       mean;
        logic [NUM_CHANNELS-1:0][SCALE_W-1:0]      scale;
    } cfg_t;

    typedef struct packed {
        logic [CH_W-1:0]  chan;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic             last;
    } pos_t;

    // zero reads as one, anything above the largest size reads as the largest size
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        begin
            if (v == '0)
                r = DIM_W'(1);
            else if (v > DIM_W'(MAX_DIM))
                r = DIM_W'(MAX_DIM);
            else
                r = v;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: design/pnc_stream_if.sv
`default_nettype none

interface pnc_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [pnc_pkg::PIX_W-1:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface pnc_norm_if;
    logic                              valid;
    logic                              ready;
    logic [pnc_pkg::IDX_W-1:0]         out_index;
    logic signed [pnc_pkg::NORM_W-1:0] norm_value;
    logic                              image_last;

    modport source (output valid, output out_index, output norm_value, output image_last,
                    input ready);
    modport sink   (input valid, input out_index, input norm_value, input image_last,
                    output ready);
endinterface

`default_nettype wire

// File: design/pnc_cfg_regs.sv
`default_nettype none

module pnc_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [pnc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pnc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output pnc_pkg::cfg_t                           cfg
);

    logic [pnc_pkg::DIM_W-1:0]                                   height_reg;
    logic [pnc_pkg::DIM_W-1:0]                                   width_reg;
    logic [pnc_pkg::NUM_CHANNELS-1:0][pnc_pkg::MEAN_W-1:0]       mean_reg;
    logic [pnc_pkg::NUM_CHANNELS-1:0][pnc_pkg::SCALE_W-1:0]      scale_reg;
    logic [pnc_pkg::AREA_W-1:0]                                  area_reg;
    logic [pnc_pkg::AREA_W-1:0]                                  area_next;
    logic [pnc_pkg::DIM_W-1:0]                                   height_eff;
    logic [pnc_pkg::DIM_W-1:0]                                   width_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= pnc_pkg::DIM_RESET;
            width_reg  <= pnc_pkg::DIM_RESET;
            mean_reg   <= {pnc_pkg::NUM_CHANNELS{pnc_pkg::MEAN_RESET}};
            scale_reg  <= {pnc_pkg::NUM_CHANNELS{pnc_pkg::SCALE_RESET}};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pnc_pkg::REG_IMAGE_HEIGHT: height_reg   <= cfg_data[pnc_pkg::DIM_W-1:0];
                pnc_pkg::REG_IMAGE_WIDTH:  width_reg    <= cfg_data[pnc_pkg::DIM_W-1:0];
                pnc_pkg::REG_MEAN_CH0:     mean_reg[0]  <= cfg_data[pnc_pkg::MEAN_W-1:0];
                pnc_pkg::REG_MEAN_CH1:     mean_reg[1]  <= cfg_data[pnc_pkg::MEAN_W-1:0];
                pnc_pkg::REG_MEAN_CH2:     mean_reg[2]  <= cfg_data[pnc_pkg::MEAN_W-1:0];
                pnc_pkg::REG_SCALE_CH0:    scale_reg[0] <= cfg_data[pnc_pkg::SCALE_W-1:0];
                pnc_pkg::REG_SCALE_CH1:    scale_reg[1] <= cfg_data[pnc_pkg::SCALE_W-1:0];
                pnc_pkg::REG_SCALE_CH2:    scale_reg[2] <= cfg_data[pnc_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign height_eff = pnc_pkg::clamp_dim(height_reg);
    assign width_eff  = pnc_pkg::clamp_dim(width_reg);

    // plane size, registered from the clamped dimension registers
    assign area_next = pnc_pkg::AREA_W'(height_eff) * pnc_pkg::AREA_W'(width_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            area_reg <= pnc_pkg::AREA_W'(1);
        else
            area_reg <= area_next;
    end

    always_comb
    begin
        cfg.height = height_eff;
        cfg.width  = width_eff;
        cfg.area   = area_reg;
        cfg.mean   = mean_reg;
        cfg.scale  = scale_reg;
    end

endmodule

`default_nettype wire

// File: design/pnc_position.sv
`default_nettype none

module pnc_position (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           advance,
    input  wire logic [pnc_pkg::DIM_W-1:0]      height,
    input  wire logic [pnc_pkg::DIM_W-1:0]      width,
    output pnc_pkg::pos_t                       pos
);

    logic [pnc_pkg::CH_W-1:0]  chan_reg, chan_next;
    logic [pnc_pkg::CNT_W-1:0] col_reg, col_next;
    logic [pnc_pkg::CNT_W-1:0] row_reg, row_next;
    logic                      last_ch, last_col, last_row;

    // a counter at or past its bound counts as being on the last position
    assign last_ch  = ({1'b0, chan_reg} + 3'd1) >= 3'(pnc_pkg::NUM_CHANNELS);
    assign last_col = ({1'b0, col_reg} + pnc_pkg::DIM_W'(1)) >= width;
    assign last_row = ({1'b0, row_reg} + pnc_pkg::DIM_W'(1)) >= height;

    always_comb
    begin
        chan_next = chan_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (!last_ch)
            chan_next = chan_reg + 2'd1;
        else
        begin
            chan_next = '0;
            if (!last_col)
                col_next = col_reg + pnc_pkg::CNT_W'(1);
            else
            begin
                col_next = '0;
                if (!last_row)
                    row_next = row_reg + pnc_pkg::CNT_W'(1);
                else
                    row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else if (advance)
        begin
            chan_reg <= chan_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

    always_comb
    begin
        pos.chan = chan_reg;
        pos.row  = row_reg;
        pos.col  = col_reg;
        pos.last = last_ch && last_col && last_row;
    end

endmodule

`default_nettype wire

// File: design/pnc_compute.sv
`default_nettype none

module pnc_compute (
    input  wire logic [pnc_pkg::PIX_W-1:0]          pixel_byte,
    input  wire pnc_pkg::pos_t                      pos,
    input  wire pnc_pkg::cfg_t                      cfg,
    output logic [pnc_pkg::IDX_W-1:0]               out_index,
    output logic signed [pnc_pkg::NORM_W-1:0]       norm_value
);

    logic [pnc_pkg::AREA_W-1:0]              row_off;
    logic [pnc_pkg::IDX_W-1:0]               plane_off;
    logic [pnc_pkg::CH_W-1:0]                cidx;
    logic [pnc_pkg::MEAN_W-1:0]              mean_sel;
    logic [pnc_pkg::SCALE_W-1:0]             scale_sel;
    logic signed [pnc_pkg::DIFF_W-1:0]       diff;
    logic signed [pnc_pkg::PROD_W-1:0]       prod;
    logic signed [pnc_pkg::QUOT_W-1:0]       quot;

    // planar index
    assign row_off = pnc_pkg::AREA_W'(pos.row) * pnc_pkg::AREA_W'(cfg.width);

    always_comb
    begin
        case (pos.chan)
            2'd0:    plane_off = '0;
            2'd1:    plane_off = pnc_pkg::IDX_W'(cfg.area);
            2'd2:    plane_off = pnc_pkg::IDX_W'({cfg.area, 1'b0});
            default: plane_off = pnc_pkg::IDX_W'(cfg.area) + pnc_pkg::IDX_W'({cfg.area, 1'b0});
        endcase
    end

    assign out_index = plane_off + pnc_pkg::IDX_W'(row_off) + pnc_pkg::IDX_W'(pos.col);

    // normalization
    assign cidx      = (pos.chan == 2'd3) ? 2'd2 : pos.chan;
    assign mean_sel  = cfg.mean[cidx];
    assign scale_sel = cfg.scale[cidx];

    assign diff = $signed({1'b0, pixel_byte, 8'd0}) - $signed({1'b0, mean_sel});
    assign prod = pnc_pkg::PROD_W'(diff) * pnc_pkg::PROD_W'($signed({1'b0, scale_sel}));

    // arithmetic shift gives floor
    assign quot = pnc_pkg::QUOT_W'(prod >>> pnc_pkg::FRAC_SHIFT);

    // in range when the bits above the result all match its sign
    always_comb
    begin
        if (!quot[pnc_pkg::QUOT_W-1] && (quot[pnc_pkg::QUOT_W-2:pnc_pkg::NORM_W-1] != '0))
            norm_value = pnc_pkg::NORM_MAX;
        else if (quot[pnc_pkg::QUOT_W-1] && (quot[pnc_pkg::QUOT_W-2:pnc_pkg::NORM_W-1] != '1))
            norm_value = pnc_pkg::NORM_MIN;
        else
            norm_value = quot[pnc_pkg::NORM_W-1:0];
    end

endmodule

`default_nettype wire

// File: design/pixel_normalize_channel_permute.sv
// an accepted pixel request passes through the input register, then the result register, to norm_out
// throughput: one pixel byte per cycle, sustained while norm_out is taken every cycle
// the rate is set by the input register / result register pair around the datapath
// reset (rst_n low, asynchronous): pipeline empties, position counters go to zero,
// registers return to height 1, width 1, means 0, scales 1.0
`default_nettype none

module pixel_normalize_channel_permute (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [pnc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pnc_pkg::CFG_DATA_W-1:0]     cfg_data,
    pnc_pixel_if.sink                               pixel_in,
    pnc_norm_if.source                              norm_out
);

    pnc_pkg::cfg_t  cfg;
    pnc_pkg::pos_t  pos;

    // input stage
    logic                               in_valid_reg, in_valid_next;
    logic [pnc_pkg::PIX_W-1:0]          in_byte_reg;
    pnc_pkg::pos_t                      in_pos_reg;

    // result stage
    logic                               out_valid_reg, out_valid_next;
    logic [pnc_pkg::IDX_W-1:0]          out_index_reg;
    logic signed [pnc_pkg::NORM_W-1:0]  out_norm_reg;
    logic                               out_last_reg;

    logic                               out_load;
    logic                               in_ready;
    logic                               accept;
    logic [pnc_pkg::IDX_W-1:0]          calc_index;
    logic signed [pnc_pkg::NORM_W-1:0]  calc_norm;

    // register file, clamped dimensions and plane size
    pnc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // row / column / channel counters, stepped on every accepted request
    pnc_position u_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .height  (cfg.height),
        .width   (cfg.width),
        .pos     (pos)
    );

    // index and normalized value from the input stage
    pnc_compute u_calc (
        .pixel_byte (in_byte_reg),
        .pos        (in_pos_reg),
        .cfg        (cfg),
        .out_index  (calc_index),
        .norm_value (calc_norm)
    );

    // result register is free when empty or being taken this cycle
    assign out_load = !out_valid_reg || norm_out.ready;
    // input register frees when it moves on to the result register
    assign in_ready = !in_valid_reg || out_load;
    assign accept   = pixel_in.valid && in_ready;

    assign pixel_in.ready = in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (out_load)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture byte together with the position it belongs to
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= pixel_in.pixel_byte;
            in_pos_reg  <= pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            out_index_reg <= calc_index;
            out_norm_reg  <= calc_norm;
            out_last_reg  <= in_pos_reg.last;
        end
    end

    assign norm_out.valid      = out_valid_reg;
    assign norm_out.out_index  = out_index_reg;
    assign norm_out.norm_value = out_norm_reg;
    assign norm_out.image_last = out_last_reg;

    // an accepted request always lands in the input register
    a_accept_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_valid_reg)
        else $error("accepted request missing from input stage");

    // a waiting input item moves into a free result register
    a_input_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_load |=> out_valid_reg)
        else $error("input stage item lost on the way to the result register");

    // the end of an image only falls on the last channel
    a_last_on_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
        pos.last |-> (pos.chan == 2'(pnc_pkg::NUM_CHANNELS - 1)))
        else $error("image end flagged away from the last channel");

    // channel counter never leaves its range
    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (pos.chan != 2'd3))
        else $error("channel counter out of range");

endmodule

`default_nettype wire

// File: test/tb_pixel_normalize_channel_permute.sv
`timescale 1ns / 1ps

module tb_pixel_normalize_channel_permute;
    import pnc_pkg::*;

    // one normalized, reordered sample as the block should give it
    typedef struct {
        logic [IDX_W-1:0]         index;
        logic signed [NORM_W-1:0] value;
        logic                     last;
    } norm_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pnc_pixel_if pix ();
    pnc_norm_if  nrm ();

    pixel_normalize_channel_permute dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_in  (pix),
        .norm_out  (nrm)
    );

    always #5 clk = ~clk;

    // pixel bytes waiting to be offered, and results waiting to come back
    logic [PIX_W-1:0] pending_bytes [$];
    norm_result_t     expected_norm [$];

    int mismatch_count = 0;

    // shadow of the register file, as last written
    logic [DIM_W-1:0]   height_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [MEAN_W-1:0]  mean_reg  [NUM_CHANNELS];
    logic [SCALE_W-1:0] scale_reg [NUM_CHANNELS];

    // position of the next byte inside the image
    logic [CH_W-1:0]  chan_cnt = '0;
    logic [CNT_W-1:0] col_cnt  = '0;
    logic [CNT_W-1:0] row_cnt  = '0;

    // idle pattern state for both sides
    bit src_steady  = 1'b0;
    bit sink_steady = 1'b0;
    int send_gap;
    int recv_stall;

    // zero reads as one, oversize reads as the largest size
    function automatic int effective_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    // idle cycles: mostly none, some short, a few long
    function automatic int idle_stretch(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // planar index plus normalized value for one byte, then step the position
    function automatic norm_result_t normalize_and_place(input logic [PIX_W-1:0] pixel);
        norm_result_t r;
        longint h;
        longint w;
        longint idx;
        longint diff;
        longint prod;
        longint q;
        int     ci;
        bit     end_ch;
        bit     end_col;
        bit     end_row;
        h  = effective_dim(height_reg);
        w  = effective_dim(width_reg);
        ci = (int'(chan_cnt) < NUM_CHANNELS) ? int'(chan_cnt) : NUM_CHANNELS - 1;

        // counters are used as held, even past a shrunk dimension
        idx = longint'(chan_cnt) * h * w + longint'(row_cnt) * w + longint'(col_cnt);

        // byte as Q8.8 minus mean, times Q8.16 scale, floor back to 8 fraction bits
        diff = longint'({pixel, 8'h00}) - longint'(mean_reg[ci]);
        prod = diff * longint'(scale_reg[ci]);
        q    = prod >>> FRAC_SHIFT;
        if (q > longint'(NORM_MAX))
            q = longint'(NORM_MAX);
        if (q < longint'(NORM_MIN))
            q = longint'(NORM_MIN);

        end_ch  = (int'(chan_cnt) + 1 >= NUM_CHANNELS);
        end_col = (longint'(col_cnt) + 1 >= w);
        end_row = (longint'(row_cnt) + 1 >= h);

        r.index = idx[IDX_W-1:0];
        r.value = q[NORM_W-1:0];
        r.last  = end_ch && end_col && end_row;

        // interleaved order: channel fastest, then column, then row
        if (!end_ch)
            chan_cnt = chan_cnt + 1'b1;
        else
        begin
            chan_cnt = '0;
            if (!end_col)
                col_cnt = col_cnt + 1'b1;
            else
            begin
                col_cnt = '0;
                if (!end_row)
                    row_cnt = row_cnt + 1'b1;
                else
                    row_cnt = '0;
            end
        end
        return r;
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // one register write on the next edge, shadow follows along
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_IMAGE_HEIGHT: height_reg   = data[DIM_W-1:0];
            REG_IMAGE_WIDTH:  width_reg    = data[DIM_W-1:0];
            REG_MEAN_CH0:     mean_reg[0]  = data[MEAN_W-1:0];
            REG_MEAN_CH1:     mean_reg[1]  = data[MEAN_W-1:0];
            REG_MEAN_CH2:     mean_reg[2]  = data[MEAN_W-1:0];
            REG_SCALE_CH0:    scale_reg[0] = data[SCALE_W-1:0];
            REG_SCALE_CH1:    scale_reg[1] = data[SCALE_W-1:0];
            REG_SCALE_CH2:    scale_reg[2] = data[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    // full register set, written back to back while the block is idle
    task automatic apply_setting(
        input logic [DIM_W-1:0]   h,
        input logic [DIM_W-1:0]   w,
        input logic [MEAN_W-1:0]  m0,
        input logic [MEAN_W-1:0]  m1,
        input logic [MEAN_W-1:0]  m2,
        input logic [SCALE_W-1:0] s0,
        input logic [SCALE_W-1:0] s1,
        input logic [SCALE_W-1:0] s2
    );
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_IMAGE_WIDTH,  CFG_DATA_W'(w));
        write_reg(REG_MEAN_CH0,     CFG_DATA_W'(m0));
        write_reg(REG_MEAN_CH1,     CFG_DATA_W'(m1));
        write_reg(REG_MEAN_CH2,     CFG_DATA_W'(m2));
        write_reg(REG_SCALE_CH0,    s0);
        write_reg(REG_SCALE_CH1,    s1);
        write_reg(REG_SCALE_CH2,    s2);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // hold off until every request is sent and every result is back,
    // checked on the falling edge so the driver has settled
    task automatic drain_pipeline();
        @(negedge clk);
        while (pending_bytes.size() != 0 || pix.valid || expected_norm.size() != 0)
            @(negedge clk);
        // pipeline of input and result registers, leave it a little margin
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return '0;
            1:       return DIM_W'(MAX_DIM);
            2:       return DIM_W'($urandom_range(MAX_DIM + 1, 8191));
            3:       return DIM_W'($urandom_range(1, MAX_DIM));
            default: return DIM_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [MEAN_W-1:0] pick_mean();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return MEAN_W'($urandom());
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0:       return '0;
            1:       return '1;
            2:       return SCALE_RESET;
            3, 4:    return SCALE_W'($urandom());
            default: return SCALE_W'($urandom_range(0, 24'h03FFFF));
        endcase
    endfunction

    // pixel request driver: one byte per accepted request, random gaps between
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix.valid      <= 1'b0;
            pix.pixel_byte <= '0;
            send_gap       <= 0;
        end
        else if (!pix.valid || pix.ready)
        begin
            // now and then switch between gappy and back-to-back sending
            if ($urandom_range(0, 63) == 0)
                src_steady = !src_steady;
            if (send_gap != 0)
            begin
                pix.valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end
            else if (pending_bytes.size() != 0)
            begin
                pix.valid      <= 1'b1;
                pix.pixel_byte <= pending_bytes.pop_front();
                send_gap       <= idle_stretch(src_steady);
            end
            else
                pix.valid <= 1'b0;
        end
    end

    // result side backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nrm.ready  <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                sink_steady = !sink_steady;
            if (recv_stall != 0)
            begin
                nrm.ready  <= 1'b0;
                recv_stall <= recv_stall - 1;
            end
            else
            begin
                nrm.ready  <= 1'b1;
                recv_stall <= idle_stretch(sink_steady);
            end
        end
    end

    // predict on each accepted pixel request, check each accepted result in order
    always @(posedge clk)
    begin : check_results
        norm_result_t want;
        if (rst_n)
        begin
            if (pix.valid && pix.ready)
                expected_norm.push_back(normalize_and_place(pix.pixel_byte));
            if (nrm.valid && nrm.ready)
            begin
                if (expected_norm.size() == 0)
                    flag_error($sformatf("result with nothing expected: index %0d value %0d last %0b",
                                         nrm.out_index, nrm.norm_value, nrm.image_last));
                else
                begin
                    want = expected_norm.pop_front();
                    if (nrm.out_index !== want.index || nrm.norm_value !== want.value ||
                        nrm.image_last !== want.last)
                        flag_error($sformatf(
                            "index exp %0d got %0d, value exp %0d got %0d, last exp %0b got %0b",
                            want.index, nrm.out_index, want.value, nrm.norm_value,
                            want.last, nrm.image_last));
                end
            end
        end
    end

    // hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int n;
        int random_count;
        int r;

        // every block input known from time zero
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        pix.valid      = 1'b0;
        pix.pixel_byte = '0;
        nrm.ready      = 1'b0;

        height_reg = DIM_RESET;
        width_reg  = DIM_RESET;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            mean_reg[c]  = MEAN_RESET;
            scale_reg[c] = SCALE_RESET;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 1x1 image, identity scale, last flag on the third byte
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h80);
        drain_pipeline();

        // saturation both ways, zero scale, full 2x1 image
        apply_setting(13'd2, 13'd1, 16'h0000, 16'hFFFF, 16'h8000,
                      24'hFFFFFF, 24'hFFFFFF, 24'h000000);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hAA);
        pending_bytes.push_back(8'h55);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h01);
        drain_pipeline();

        // zero height reads as one, oversize width reads as the largest size;
        // tiny scale so negative values floor to minus one
        apply_setting(13'd0, 13'd8191, 16'h1234, 16'h0080, 16'h7F80,
                      24'h010000, 24'h00C000, 24'h000001);
        pending_bytes.push_back(8'h12);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h7F);
        pending_bytes.push_back(8'h7E);
        pending_bytes.push_back(8'h01);
        pending_bytes.push_back(8'hFE);
        drain_pipeline();

        // largest image: the channel planes lie the largest plane size apart
        apply_setting(13'd4097, 13'd4096, 16'h00FF, 16'hFF00, 16'h0101,
                      24'h800000, 24'h7FFFFF, 24'h123456);
        pending_bytes.push_back(8'hC3);
        pending_bytes.push_back(8'h3C);
        pending_bytes.push_back(8'hFF);
        drain_pipeline();

        // width shrunk mid-image: column already past the new end, must wrap
        apply_setting(13'd1, 13'd2, 16'h4000, 16'h2000, 16'h1000,
                      24'h020000, 24'h008000, 24'h010000);
        pending_bytes.push_back(8'h40);
        pending_bytes.push_back(8'h20);
        pending_bytes.push_back(8'h10);
        pending_bytes.push_back(8'h99);
        drain_pipeline();

        // random settings, each phase ends with the sender held until all results are back;
        // counters carry over, so dimension changes often land mid-image
        random_count = 0;
        while (random_count < 1000)
        begin
            apply_setting(pick_dim(), pick_dim(), pick_mean(), pick_mean(), pick_mean(),
                          pick_scale(), pick_scale(), pick_scale());
            n = $urandom_range(5, 60);
            for (int i = 0; i < n; i++)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    pending_bytes.push_back(8'h00);
                else if (r == 1)
                    pending_bytes.push_back(8'hFF);
                else
                    pending_bytes.push_back(PIX_W'($urandom()));
            end
            random_count += n;
            drain_pipeline();
        end

        // catch any stray result after the last expected one
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_norm.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
design/pnc_pkg.sv
design/pnc_stream_if.sv
design/pnc_cfg_regs.sv
design/pnc_position.sv
design/pnc_compute.sv
design/pixel_normalize_channel_permute.sv
test/tb_pixel_normalize_channel_permute.sv
